@@ sv/ttw_pkg.sv @@
// Shared types and constants for the two-tube waveguide.
// No dependencies; the stream interfaces and the top level import it.
package ttw_pkg;

    // Sample and register widths
    localparam int SMP_W  = 16;
    localparam int CFG_W  = 16;
    localparam int LEN_W  = 4;
    localparam int IDX_W  = 2;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_SCATTER_COEF = 2'd0,
        CFG_LOSS_GAIN    = 2'd1,
        CFG_FIRST_LEN    = 2'd2,
        CFG_SECOND_LEN   = 2'd3
    } t_cfg_idx;

    // Register reset values
    localparam logic signed [CFG_W-1:0] RST_SCATTER_COEF = -16'sd12812;
    localparam logic [CFG_W-1:0]        RST_LOSS_GAIN    = 16'd32440;
    localparam logic [LEN_W-1:0]        RST_FIRST_LEN    = 4'd7;
    localparam logic [LEN_W-1:0]        RST_SECOND_LEN   = 4'd2;

    // Unity in the Q1.14 junction coefficient format
    localparam logic signed [CFG_W:0]   UNITY_Q14        = 17'sd16384;

    // Shift of the end filter product back to the inner format
    localparam int LOSS_SHIFT = 16;
    // Shift of the junction products back to the inner format
    localparam int COEF_SHIFT = 14;

endpackage

@@ sv/ttw_in_if.sv @@
// Input sample stream: valid/ready handshake with one excitation word.
// Depends on ttw_pkg for the sample width.
interface ttw_in_if;
    import ttw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample_in;
    logic                    block_end;

    modport source (output valid, output sample_in, output block_end, input ready);
    modport sink   (input valid, input sample_in, input block_end, output ready);
endinterface

@@ sv/ttw_out_if.sv @@
// Output sample stream: valid/ready handshake with one result word.
// Depends on ttw_pkg for the sample width.
interface ttw_out_if;
    import ttw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample_out;
    logic                    block_end_out;

    modport source (output valid, output sample_out, output block_end_out, input ready);
    modport sink   (input valid, input sample_out, input block_end_out, output ready);
endinterface

@@ sv/two_tube_waveguide.sv @@
// Two-tube waveguide: takes one Q1.15 excitation word per cycle and returns one Q1.15 word
// per cycle while the output is not stalled, the second tube's right-going tap read before
// the update. Each accepted word is folded into the state in one pass: the ring entries at
// the tube pointers sit in read registers, and parallel multiplies, adds and saturation
// produce the new ring entries, the end filter samples and the result, which is registered
// into the output register, or into a one-word skid register if the output is stalled;
// input stalls while the skid is full. Sustained rate is one word per cycle, set by that
// single update pass. Rings clear at reset through per-entry valid bits, so the block is
// ready right after reset. Write the configuration only while no word is in flight; a
// length write sends both pointers to zero. Depends on ttw_pkg, ttw_in_if and ttw_out_if.
module two_tube_waveguide #(
    parameter int MAX_DELAY  = 8,
    parameter int INNER_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    ttw_in_if.sink                    i_sample_if,
    ttw_out_if.source                 o_sample_if,
    input  logic                      i_cfg_we,
    input  ttw_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [ttw_pkg::CFG_W-1:0] i_cfg_data
);
    import ttw_pkg::*;

    localparam int IB   = INNER_BITS;
    localparam int FRAC = IB - 4;
    localparam int UP   = (FRAC >= 15) ? FRAC - 15 : 0;
    localparam int DN   = (FRAC < 15) ? 15 - FRAC : 0;
    localparam int PW   = $clog2(MAX_DELAY);
    localparam int CW   = (PW + 1 > LEN_W) ? PW + 1 : LEN_W;
    localparam int WW   = IB + 18;

    localparam logic [CW-1:0]          LEN_MAX   = CW'(MAX_DELAY);
    localparam logic [CW-1:0]          LEN_MIN   = CW'(1);
    localparam logic signed [IB+1:0]   Q15_MAX   = (IB+2)'(32767);
    localparam logic signed [IB+1:0]   Q15_MIN   = -(IB+2)'(32768);
    localparam logic signed [IB+1:0]   TRUNC_BIAS = (IB+2)'((64'd1 << UP) - 64'd1);

    // Saturate a wide intermediate to the inner signed range
    function automatic logic signed [IB-1:0] sat_ib(input logic signed [WW-1:0] v);
        logic signed [IB-1:0] res;
        if (v[WW-1:IB-1] == {(WW-IB+1){1'b0}} || v[WW-1:IB-1] == {(WW-IB+1){1'b1}}) begin
            res = v[IB-1:0];
        end else if (v[WW-1]) begin
            res = {1'b1, {(IB-1){1'b0}}};
        end else begin
            res = {1'b0, {(IB-1){1'b1}}};
        end
        return res;
    endfunction

    // Configuration registers
    logic signed [CFG_W-1:0] r_coef;
    logic [CFG_W-1:0]        r_loss;
    logic [LEN_W-1:0]        r_len1;
    logic [LEN_W-1:0]        r_len2;

    // Ring memories and per-entry valid bits
    logic signed [IB-1:0] r_t1r_mem [MAX_DELAY];
    logic signed [IB-1:0] r_t1l_mem [MAX_DELAY];
    logic signed [IB-1:0] r_t2r_mem [MAX_DELAY];
    logic signed [IB-1:0] r_t2l_mem [MAX_DELAY];
    logic [MAX_DELAY-1:0] r_v1;
    logic [MAX_DELAY-1:0] r_v2;

    // Pointers, read registers and filter history
    logic [PW-1:0]        r_p1, r_p2;
    logic signed [IB-1:0] r_a, r_b, r_c, r_d;
    logic signed [IB-1:0] r_f1p, r_f2p;

    // Output register and skid stage
    logic                    r_ov, r_sv;
    logic signed [SMP_W-1:0] r_osmp, r_ssmp;
    logic                    r_oend, r_send;

    logic acc, out_fire, len_wr;
    logic [CW-1:0] eff1, eff2;
    logic [PW:0]   inc1, inc2;
    logic [PW-1:0] n_p1, n_p2;

    logic signed [IB:0]    smp_w, in_inner, t1r_sum;
    logic signed [IB:0]    sum1, sum2;
    logic signed [CFG_W:0] loss_s, kp, km, k_s;
    logic signed [WW-1:0]  pf1, pf2, pj2r, pj1l;
    logic signed [IB-1:0]  n_t1r, n_t1l, n_t2r, n_t2l;
    logic signed [IB+1:0]  cw;
    logic signed [SMP_W-1:0] n_q15;

    // Handshake
    assign acc              = i_sample_if.valid && !r_sv;
    assign out_fire         = r_ov && o_sample_if.ready;
    assign i_sample_if.ready = !r_sv;
    assign o_sample_if.valid = r_ov;
    assign o_sample_if.sample_out    = r_osmp;
    assign o_sample_if.block_end_out = r_oend;
    assign len_wr = i_cfg_we && (i_cfg_idx == CFG_FIRST_LEN || i_cfg_idx == CFG_SECOND_LEN);

    // Clamp the lengths and step the pointers
    always_comb begin
        eff1 = CW'(r_len1);
        eff2 = CW'(r_len2);
        if (eff1 < LEN_MIN) eff1 = LEN_MIN;
        if (eff1 > LEN_MAX) eff1 = LEN_MAX;
        if (eff2 < LEN_MIN) eff2 = LEN_MIN;
        if (eff2 > LEN_MAX) eff2 = LEN_MAX;
        inc1 = {1'b0, r_p1} + (PW+1)'(1);
        inc2 = {1'b0, r_p2} + (PW+1)'(1);
        n_p1 = (CW'(inc1) >= eff1) ? '0 : inc1[PW-1:0];
        n_p2 = (CW'(inc2) >= eff2) ? '0 : inc2[PW-1:0];
    end

    // Lossy end filters
    assign loss_s = $signed({1'b0, r_loss});
    assign sum1   = (IB+1)'(r_f1p) + (IB+1)'(r_b);
    assign sum2   = (IB+1)'(r_f2p) + (IB+1)'(r_c);
    assign pf1    = WW'(loss_s) * WW'(sum1);
    assign pf2    = WW'(loss_s) * WW'(sum2);

    // Kelly-Lochbaum junction
    assign k_s  = (CFG_W+1)'(r_coef);
    assign kp   = UNITY_Q14 + k_s;
    assign km   = UNITY_Q14 - k_s;
    assign pj2r = WW'(r_a) * WW'(kp) - WW'(k_s) * WW'(r_d);
    assign pj1l = WW'(r_a) * WW'(k_s) + WW'(km) * WW'(r_d);

    // Excitation into the inner format, then the new ring words
    assign smp_w    = $signed({{(IB-15){i_sample_if.sample_in[SMP_W-1]}}, i_sample_if.sample_in});
    assign in_inner = (smp_w <<< UP) >>> DN;
    assign n_t2l    = sat_ib(pf2 >>> LOSS_SHIFT);
    assign t1r_sum  = in_inner + (IB+1)'(sat_ib(pf1 >>> LOSS_SHIFT));
    assign n_t1r    = sat_ib(WW'(t1r_sum));
    assign n_t2r    = sat_ib(pj2r >>> COEF_SHIFT);
    assign n_t1l    = sat_ib(pj1l >>> COEF_SHIFT);

    // Tap back to Q1.15, truncating toward zero, then saturate
    always_comb begin
        cw = (IB+2)'(r_c);
        if (r_c[IB-1]) cw = cw + TRUNC_BIAS;
        cw = (cw >>> UP) <<< DN;
        if (cw > Q15_MAX)      n_q15 = 16'sh7fff;
        else if (cw < Q15_MIN) n_q15 = 16'sh8000;
        else                   n_q15 = cw[SMP_W-1:0];
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= RST_SCATTER_COEF;
            r_loss <= RST_LOSS_GAIN;
            r_len1 <= RST_FIRST_LEN;
            r_len2 <= RST_SECOND_LEN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCATTER_COEF: r_coef <= $signed(i_cfg_data);
                CFG_LOSS_GAIN:    r_loss <= i_cfg_data;
                CFG_FIRST_LEN:    r_len1 <= i_cfg_data[LEN_W-1:0];
                CFG_SECOND_LEN:   r_len2 <= i_cfg_data[LEN_W-1:0];
                default:          r_len2 <= r_len2;
            endcase
        end
    end

    // Write the rings at the current pointers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_t1r_mem[r_p1] <= n_t1r;
            r_t1l_mem[r_p1] <= n_t1l;
            r_t2r_mem[r_p2] <= n_t2r;
            r_t2l_mem[r_p2] <= n_t2l;
        end
    end

    // Advance pointers, prefetch the next entries, track valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1  <= '0;
            r_p2  <= '0;
            r_v1  <= '0;
            r_v2  <= '0;
            r_a   <= '0;
            r_b   <= '0;
            r_c   <= '0;
            r_d   <= '0;
            r_f1p <= '0;
            r_f2p <= '0;
        end else if (len_wr) begin
            r_p1 <= '0;
            r_p2 <= '0;
            r_a  <= r_v1[0] ? r_t1r_mem[0] : '0;
            r_b  <= r_v1[0] ? r_t1l_mem[0] : '0;
            r_c  <= r_v2[0] ? r_t2r_mem[0] : '0;
            r_d  <= r_v2[0] ? r_t2l_mem[0] : '0;
        end else if (acc) begin
            r_p1        <= n_p1;
            r_p2        <= n_p2;
            r_v1[r_p1]  <= 1'b1;
            r_v2[r_p2]  <= 1'b1;
            r_f1p       <= r_b;
            r_f2p       <= r_c;
            // a length of one reads back the word just written
            if (n_p1 == r_p1) begin
                r_a <= n_t1r;
                r_b <= n_t1l;
            end else begin
                r_a <= r_v1[n_p1] ? r_t1r_mem[n_p1] : '0;
                r_b <= r_v1[n_p1] ? r_t1l_mem[n_p1] : '0;
            end
            if (n_p2 == r_p2) begin
                r_c <= n_t2r;
                r_d <= n_t2l;
            end else begin
                r_c <= r_v2[n_p2] ? r_t2r_mem[n_p2] : '0;
                r_d <= r_v2[n_p2] ? r_t2l_mem[n_p2] : '0;
            end
        end
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (acc) begin
            if (!r_ov || out_fire) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (out_fire) begin
            if (r_sv) begin
                r_sv <= 1'b0;
            end else begin
                r_ov <= 1'b0;
            end
        end
    end

    // Output word payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (!r_ov || out_fire) begin
                r_osmp <= n_q15;
                r_oend <= i_sample_if.block_end;
            end else begin
                r_ssmp <= n_q15;
                r_send <= i_sample_if.block_end;
            end
        end else if (out_fire && r_sv) begin
            r_osmp <= r_ssmp;
            r_oend <= r_send;
        end
    end

    // A word in the skid stage always has one ahead of it
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid stage holds a word while output register is empty");

    // A word accepted against a stalled output lands in the skid stage
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && r_ov && !o_sample_if.ready) |=> r_sv)
        else $error("accepted word lost under output stall");

    // Pointers stay inside the clamped tube lengths
    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_p1) < eff1) && (CW'(r_p2) < eff2))
        else $error("tube pointer outside its length");

    // A length write sends both pointers home
    a_len_wr_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        len_wr |=> (r_p1 == '0 && r_p2 == '0))
        else $error("pointers not cleared by length write");

endmodule
